[design/dba_pkg.sv]
// types, constants and register codes shared by the disk block allocator
package dba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int NUM_LIMIT  = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int BN_W      = 12;
  localparam int NUM_W     = 13;
  localparam int BWORD_W   = BN_W - BIT_W;
  localparam int MAP_WORDS = NUM_LIMIT / WORD_BITS;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int STATUS_W  = 3;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
  localparam logic [1:0] REG_ROOT_BLOCK   = 2'd1;
  localparam logic [1:0] REG_BITMAP_BLOCK = 2'd2;

  localparam logic [NUM_W-1:0] BLOCK_COUNT_RST = 13'd1760;
  localparam logic [BN_W-1:0]  ROOT_RST        = 12'd880;
  localparam logic [BN_W-1:0]  BITMAP_RST      = 12'd881;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd4;

  // first block that may ever be granted
  localparam logic [BN_W-1:0] FIRST_BLOCK = 12'd2;

  typedef logic [BN_W-1:0]      bn_t;
  typedef logic [BWORD_W-1:0]   bword_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [NUM_W-1:0] block_count;
    bn_t              root_block;
    bn_t              bitmap_block;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } pick_t;

endpackage

[design/dba_req_if.sv]
// request channel: operation and block number
interface dba_req_if;
  logic             valid;
  logic             ready;
  logic             op;
  dba_pkg::bn_t     block_number;

  modport source (output valid, output op, output block_number, input ready);
  modport sink   (input valid, input op, input block_number, output ready);
endinterface

[design/dba_rsp_if.sv]
// response channel: granted block and status
interface dba_rsp_if;
  logic                               valid;
  logic                               ready;
  dba_pkg::bn_t                       granted_block;
  logic [dba_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface

[design/dba_ram.sv]
// generic one-write one-read ram with registered read data
module dba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dba_cfg.sv]
// apb configuration registers of the allocator
module dba_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dba_pkg::APB_AW-1:0]  paddr,
  input  logic [dba_pkg::APB_DW-1:0]  pwdata,
  output logic [dba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output dba_pkg::cfg_t               cfg
);

  logic [1:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_count  <= dba_pkg::BLOCK_COUNT_RST;
      cfg.root_block   <= dba_pkg::ROOT_RST;
      cfg.bitmap_block <= dba_pkg::BITMAP_RST;
    end else if (wr) begin
      unique case (reg_idx)
        dba_pkg::REG_BLOCK_COUNT:  cfg.block_count  <= pwdata[dba_pkg::NUM_W-1:0];
        dba_pkg::REG_ROOT_BLOCK:   cfg.root_block   <= pwdata[dba_pkg::BN_W-1:0];
        dba_pkg::REG_BITMAP_BLOCK: cfg.bitmap_block <= pwdata[dba_pkg::BN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dba_pkg::REG_BLOCK_COUNT:
        prdata = dba_pkg::APB_DW'(cfg.block_count);
      dba_pkg::REG_ROOT_BLOCK:
        prdata = dba_pkg::APB_DW'(cfg.root_block);
      dba_pkg::REG_BITMAP_BLOCK:
        prdata = dba_pkg::APB_DW'(cfg.bitmap_block);
      default:
        prdata = '0;
    endcase
  end

endmodule

[design/dba_word_eval.sv]
// finds the lowest free candidate block inside one map word, or the highest when descending
module dba_word_eval (
  input  dba_pkg::bword_t  word_idx,
  input  dba_pkg::word_t   data,
  input  logic             descend,
  input  dba_pkg::bn_t     lo,
  input  dba_pkg::bn_t     hi,
  input  dba_pkg::bn_t     root_block,
  input  dba_pkg::bn_t     bitmap_block,
  output dba_pkg::pick_t   pick
);

  dba_pkg::word_t ones;
  dba_pkg::word_t ge_mask;
  dba_pkg::word_t le_mask;
  dba_pkg::word_t rsv_mask;
  dba_pkg::word_t cand;
  logic [dba_pkg::BIT_W-1:0] lo_bit;
  logic [dba_pkg::BIT_W-1:0] hi_bit;
  logic [dba_pkg::BIT_W-1:0] low_idx;
  logic [dba_pkg::BIT_W-1:0] high_idx;

  assign ones = '1;

  always_comb begin
    lo_bit = lo[dba_pkg::BIT_W-1:0];
    hi_bit = hi[dba_pkg::BIT_W-1:0];

    // lower bound of the search window
    if (word_idx > lo[dba_pkg::BN_W-1:dba_pkg::BIT_W]) begin
      ge_mask = ones;
    end else if (word_idx == lo[dba_pkg::BN_W-1:dba_pkg::BIT_W]) begin
      ge_mask = ones << lo_bit;
    end else begin
      ge_mask = '0;
    end

    // upper bound, inclusive
    if (word_idx < hi[dba_pkg::BN_W-1:dba_pkg::BIT_W]) begin
      le_mask = ones;
    end else if (word_idx == hi[dba_pkg::BN_W-1:dba_pkg::BIT_W]) begin
      le_mask = ones >> (dba_pkg::BIT_W'(dba_pkg::WORD_BITS - 1) - hi_bit);
    end else begin
      le_mask = '0;
    end

    // blocks 0 and 1, root and bitmap are never handed out
    rsv_mask = '0;
    if (word_idx == '0) begin
      rsv_mask[1:0] = 2'b11;
    end
    if (root_block[dba_pkg::BN_W-1:dba_pkg::BIT_W] == word_idx) begin
      rsv_mask[root_block[dba_pkg::BIT_W-1:0]] = 1'b1;
    end
    if (bitmap_block[dba_pkg::BN_W-1:dba_pkg::BIT_W] == word_idx) begin
      rsv_mask[bitmap_block[dba_pkg::BIT_W-1:0]] = 1'b1;
    end

    cand = ~data & ge_mask & le_mask & ~rsv_mask;

    low_idx  = '0;
    high_idx = '0;
    for (int i = 0; i < dba_pkg::WORD_BITS; i++) begin
      if (cand[i]) begin
        high_idx = dba_pkg::BIT_W'(i);
      end
    end
    for (int i = dba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        low_idx = dba_pkg::BIT_W'(i);
      end
    end

    pick.found = |cand;
    pick.idx   = descend ? high_idx : low_idx;
  end

endmodule

[design/disk_block_allocator_unit.sv]
// top level of the disk block allocator: sequencer, use map and response register
// The block keeps one in-use bit per volume block in a 32-bit-wide map memory
// (one word per 32 blocks) and serves one request at a time. After reset a
// clearing pass zeroes the map, one word per cycle, over all MAP_WORDS words (128
// at the default size); no request is taken then, configuration writes are.
// A free checks its block and clears its bit in the FREE state, then loads the
// response in the DONE state once the output register is free. An allocate
// streams map words through the registered read port, one word per cycle,
// upward from just above the root block and then downward from just below it;
// when the volume is full every word of both windows is read (the word holding
// the root is read on both sides). A new request is taken while the previous
// response still waits in the output register.
module disk_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  dba_req_if.sink                     req,
  dba_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dba_pkg::APB_AW-1:0]  paddr,
  input  logic [dba_pkg::APB_DW-1:0]  pwdata,
  output logic [dba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  dba_pkg::cfg_t cfg;

  logic [2:0] state;
  logic [2:0] state_next;

  // clearing pass
  logic [dba_pkg::WORD_AW-1:0] clr_addr;

  // request held during its work
  dba_pkg::bn_t bn;

  // read issue side of the scan
  logic            iss_phase;
  logic            iss_done;
  dba_pkg::bword_t iss_word;

  // evaluate side, aligned with the ram read data
  logic            ev_valid;
  logic            ev_phase;
  dba_pkg::bword_t ev_word;

  // finished result waiting for the response register
  dba_pkg::bn_t                 res_block;
  logic [dba_pkg::STATUS_W-1:0] res_status;

  // map memory ports
  logic                        ram_we;
  logic [dba_pkg::WORD_AW-1:0] ram_waddr;
  dba_pkg::word_t              ram_wdata;
  logic [dba_pkg::WORD_AW-1:0] ram_raddr;
  dba_pkg::word_t              ram_rdata;

  // volume geometry derived from the registers
  logic [dba_pkg::NUM_W-1:0] n_eff;
  logic [dba_pkg::NUM_W-1:0] root_ext;
  logic [dba_pkg::NUM_W-1:0] up_lo_ext;
  logic [dba_pkg::NUM_W-1:0] dn_hi_ext;
  logic                      up_en;
  logic                      dn_en;
  dba_pkg::bn_t              up_lo;
  dba_pkg::bn_t              up_hi;
  dba_pkg::bn_t              dn_hi;

  dba_pkg::bn_t   ev_lo;
  dba_pkg::bn_t   ev_hi;
  dba_pkg::pick_t pick;

  // free request checks
  logic           fr_range;
  logic           fr_rsv;
  logic           fr_used;
  dba_pkg::word_t fr_mask;

  logic req_xfer;
  logic rsp_free;
  logic scan_full;

  dba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dba_ram #(
    .WIDTH (dba_pkg::WORD_BITS),
    .DEPTH (dba_pkg::MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // usable block count is capped at the map size
  always_comb begin
    if (cfg.block_count > dba_pkg::NUM_W'(dba_pkg::NUM_LIMIT)) begin
      n_eff = dba_pkg::NUM_W'(dba_pkg::NUM_LIMIT);
    end else begin
      n_eff = cfg.block_count;
    end
    root_ext  = dba_pkg::NUM_W'(cfg.root_block);
    up_lo_ext = root_ext + 1'b1;
    up_en     = up_lo_ext < n_eff;
    up_lo     = up_lo_ext[dba_pkg::BN_W-1:0];
    up_hi     = dba_pkg::BN_W'(n_eff - 1'b1);
    // downward window ends at the lower of root - 1 and the last block
    dn_en     = (root_ext > dba_pkg::NUM_W'(2)) && (n_eff > dba_pkg::NUM_W'(2));
    if (root_ext - 1'b1 < n_eff - 1'b1) begin
      dn_hi_ext = root_ext - 1'b1;
    end else begin
      dn_hi_ext = n_eff - 1'b1;
    end
    dn_hi = dn_hi_ext[dba_pkg::BN_W-1:0];
  end

  assign ev_lo = ev_phase ? dba_pkg::FIRST_BLOCK : up_lo;
  assign ev_hi = ev_phase ? dn_hi : up_hi;

  dba_word_eval u_word_eval (
    .word_idx     (ev_word),
    .data         (ram_rdata),
    .descend      (ev_phase),
    .lo           (ev_lo),
    .hi           (ev_hi),
    .root_block   (cfg.root_block),
    .bitmap_block (cfg.bitmap_block),
    .pick         (pick)
  );

  always_comb begin
    fr_range = dba_pkg::NUM_W'(bn) >= n_eff;
    fr_rsv   = (bn < dba_pkg::FIRST_BLOCK) || (bn == cfg.root_block)
            || (bn == cfg.bitmap_block);
    fr_used  = ram_rdata[bn[dba_pkg::BIT_W-1:0]];
    fr_mask  = '0;
    fr_mask[bn[dba_pkg::BIT_W-1:0]] = 1'b1;
  end

  assign req_xfer  = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;
  // nothing left to read and nothing in flight: volume full
  assign scan_full = iss_done && !ev_valid;
  assign req.ready = (state == S_IDLE);

  // map read address: request word when idle, scan pointer otherwise
  always_comb begin
    if (state == S_IDLE) begin
      ram_raddr = req.block_number[dba_pkg::BIT_W +: dba_pkg::WORD_AW];
    end else begin
      ram_raddr = iss_word[dba_pkg::WORD_AW-1:0];
    end
  end

  // map write: clearing pass, grant of a found block, or release
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN && ev_valid && pick.found) begin
      ram_we    = 1'b1;
      ram_waddr = ev_word[dba_pkg::WORD_AW-1:0];
      ram_wdata = ram_rdata | (dba_pkg::word_t'(1) << pick.idx);
    end else if (state == S_FREE && !fr_range && !fr_rsv && fr_used) begin
      ram_we    = 1'b1;
      ram_waddr = bn[dba_pkg::BIT_W +: dba_pkg::WORD_AW];
      ram_wdata = ram_rdata & ~fr_mask;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == dba_pkg::WORD_AW'(dba_pkg::MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          state_next = (req.op == dba_pkg::OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        if ((ev_valid && pick.found) || scan_full) begin
          state_next = S_DONE;
        end
      end
      S_FREE: state_next = S_DONE;
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ev_valid  <= 1'b0;
      iss_done  <= 1'b1;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (state == S_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      if (state == S_IDLE && req_xfer) begin
        ev_valid <= 1'b0;
        // pick the first window of the search
        if (up_en) begin
          iss_phase <= 1'b0;
          iss_word  <= up_lo[dba_pkg::BN_W-1:dba_pkg::BIT_W];
          iss_done  <= 1'b0;
        end else if (dn_en) begin
          iss_phase <= 1'b1;
          iss_word  <= dn_hi[dba_pkg::BN_W-1:dba_pkg::BIT_W];
          iss_done  <= 1'b0;
        end else begin
          iss_done <= 1'b1;
        end
      end else if (state == S_SCAN) begin
        ev_valid <= !iss_done;
        ev_phase <= iss_phase;
        ev_word  <= iss_word;
        if (!iss_done) begin
          if (!iss_phase) begin
            if (iss_word == up_hi[dba_pkg::BN_W-1:dba_pkg::BIT_W]) begin
              // upward window exhausted, turn below the root
              if (dn_en) begin
                iss_phase <= 1'b1;
                iss_word  <= dn_hi[dba_pkg::BN_W-1:dba_pkg::BIT_W];
              end else begin
                iss_done <= 1'b1;
              end
            end else begin
              iss_word <= iss_word + 1'b1;
            end
          end else begin
            if (iss_word == '0) begin
              iss_done <= 1'b1;
            end else begin
              iss_word <= iss_word - 1'b1;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_xfer) begin
      bn <= req.block_number;
    end

    if (state == S_SCAN) begin
      if (ev_valid && pick.found) begin
        res_block  <= {ev_word, pick.idx};
        res_status <= dba_pkg::ST_OK;
      end else begin
        res_block  <= '0;
        res_status <= dba_pkg::ST_FULL;
      end
    end else if (state == S_FREE) begin
      res_block <= '0;
      if (fr_range) begin
        res_status <= dba_pkg::ST_RANGE;
      end else if (fr_rsv) begin
        res_status <= dba_pkg::ST_RESERVED;
      end else if (!fr_used) begin
        res_status <= dba_pkg::ST_FREE;
      end else begin
        res_status <= dba_pkg::ST_OK;
      end
    end

    if (state == S_DONE && rsp_free) begin
      rsp.granted_block <= res_block;
      rsp.status        <= res_status;
    end
  end

  // a refused request never names a block
  a_refused_no_block: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != dba_pkg::ST_OK) |-> (rsp.granted_block == '0))
    else $error("refused response carries a block number");

  // map is only marked during a scan for a word that was actually read
  a_scan_write_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> (ev_valid && pick.found))
    else $error("map write during scan without a found block");

  // an accepted request always starts its work next cycle
  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state == S_SCAN || state == S_FREE))
    else $error("accepted request did not start");

  // the response register is loaded only when it is free
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !rsp_free) |=> (state == S_DONE))
    else $error("result left while response register was busy");

endmodule
